### rtl/core/rset_pkg.sv
// package for the randomised set table: sizes, operation codes, random generator taps
// and the structs passed between the core and its remainder pipeline; no dependencies
`default_nettype none

package rset_pkg;

   // table geometry
   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int OP_W     = 2;

   // remainder pipeline: bits of the dividend retired per stage
   localparam int MOD_STEPS  = 8;
   localparam int MOD_STAGES = DATA_W / MOD_STEPS;

   // operation codes
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_GET    = 2'd2;

   // galois lfsr taps, seed after reset and the empty pick marker
   localparam logic [DATA_W-1:0] LFSR_TAPS = 32'h8020_0003;
   localparam logic [DATA_W-1:0] LFSR_INIT = 32'h0000_0001;
   localparam logic [DATA_W-1:0] NO_PICK   = 32'hFFFF_FFFF;

   // one sample sent to the remainder pipeline
   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] dividend;
      logic [CNT_W-1:0]  divisor;
      logic [IDX_W-1:0]  slot;
   } mod_req_type;

   // sample leaving the remainder pipeline, plus occupancy
   typedef struct packed {
      logic             busy;
      logic             valid;
      logic             zero;
      logic [IDX_W-1:0] slot;
   } mod_rsp_type;

endpackage

`default_nettype wire

### rtl/core/rset_if.sv
// valid/ready channel interfaces for the randomised set table request and response
// depends on rset_pkg for widths
`default_nettype none

interface rset_req_if import rset_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          operation;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, operation, value, input ready);
   modport sink   (input valid, operation, value, output ready);
endinterface

interface rset_rsp_if import rset_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     succeeded;
   logic signed [DATA_W-1:0] picked_value;
   logic                     table_full;

   modport source (output valid, succeeded, picked_value, table_full, input ready);
   modport sink   (input valid, succeeded, picked_value, table_full, output ready);
endinterface

`default_nettype wire

### rtl/core/randomized_set_table_core.sv
// randomised set table: bounded set of distinct 32-bit values with random pick
// depends on rset_pkg, rset_req_if, rset_rsp_if and rset_mod_pipe
//
// usage
//   req_if carries one transaction per operation (insert, remove, get random) and a value;
//   rsp_if returns exactly one transaction per request: succeeded, picked_value and
//   table_full. csr_wr_en with csr_wr_data loads the random seed (zero loads one).
//   The values sit in a single-port memory with a registered read port; valid bits,
//   the element count and the lfsr are flip-flops.
// sequencing
//   one request at a time. Insert and remove scan every slot of the memory, one read per
//   cycle, then pass the settle and finish states. Get random walks the slots one per cycle,
//   feeds each occupied slot to a remainder pipeline of MOD_STAGES stages, drains it, then
//   reads the picked slot in the fetch state. Get random on an empty set and unused codes
//   go straight to the finish state. A new request is taken the cycle after the response
//   register is loaded, even if that response is still waiting.
// reset and stall
//   synchronous reset empties the set, clears the count and loads the lfsr with one; the
//   memory itself is not cleared. When rsp_if.ready is low the response is held and the
//   next completed operation waits until the response register is free.
`default_nettype none

module randomized_set_table_core import rset_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [DATA_W-1:0] csr_wr_data,
   rset_req_if.sink          req_if,
   rset_rsp_if.source        rsp_if
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SCAN   = 7'b0000010,
      ST_SETTLE = 7'b0000100,
      ST_WALK   = 7'b0001000,
      ST_DRAIN  = 7'b0010000,
      ST_FETCH  = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);

   state_type         state_ff, state_in;
   logic [OP_W-1:0]   op_ff;
   logic [DATA_W-1:0] val_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [CAPACITY-1:0] slot_valid_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [DATA_W-1:0] lfsr_ff, lfsr_next;
   logic [CNT_W-1:0]  k_ff;

   // search results
   logic              cmp_vld_ff, cmp_slot_ok_ff;
   logic [IDX_W-1:0]  cmp_idx_ff;
   logic              found_ff;
   logic [IDX_W-1:0]  found_idx_ff;
   logic              free_found_ff;
   logic [IDX_W-1:0]  free_idx_ff;
   logic              pick_found_ff;
   logic [IDX_W-1:0]  pick_idx_ff;

   // value memory
   logic [DATA_W-1:0] mem [CAPACITY];
   logic [DATA_W-1:0] mem_rd_data_ff;
   logic              mem_re, mem_we;
   logic [IDX_W-1:0]  mem_ra;

   // response register
   logic                     rsp_valid_ff;
   logic                     rsp_ok_ff, rsp_full_ff;
   logic signed [DATA_W-1:0] rsp_pick_ff;

   // finish stage decisions
   logic              finish_go;
   logic              fin_ok, fin_full, fin_set, fin_clr;
   logic [DATA_W-1:0] fin_pick;

   mod_req_type mod_req;
   mod_rsp_type mod_rsp;

   logic req_take;
   logic walk_hit;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_take     = req_if.valid && req_if.ready;
   assign finish_go    = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_if.ready);
   assign walk_hit     = (state_ff == ST_WALK) && slot_valid_ff[idx_ff];

   // next lfsr value
   assign lfsr_next = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? LFSR_TAPS : '0);

   // state machine
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_if.operation == OP_INSERT || req_if.operation == OP_REMOVE) begin
                  state_in = ST_SCAN;
               end else if (req_if.operation == OP_GET && count_ff != '0) begin
                  state_in = ST_WALK;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            if (idx_ff == IDX_LAST) state_in = ST_SETTLE;
         end
         ST_SETTLE: state_in = ST_FINISH;
         ST_WALK: begin
            if (idx_ff == IDX_LAST) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!mod_rsp.busy) state_in = (k_ff != '0) ? ST_FETCH : ST_FINISH;
         end
         ST_FETCH: state_in = ST_FINISH;
         ST_FINISH: begin
            if (finish_go) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // request capture and slot counter
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff  <= req_if.operation;
         val_ff <= req_if.value;
      end
      if (req_take) begin
         idx_ff <= '0;
      end else if (state_ff == ST_SCAN || state_ff == ST_WALK) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   // memory read address
   assign mem_re = (state_ff == ST_SCAN) || (state_ff == ST_FETCH);
   assign mem_ra = (state_ff == ST_FETCH) ? pick_idx_ff : idx_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[free_idx_ff] <= val_ff;
      end
      if (mem_re) begin
         mem_rd_data_ff <= mem[mem_ra];
      end
   end

   // search: compare stage in the cycle after the read, lowest free slot tracked in order
   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= (state_ff == ST_SCAN);
      end
      cmp_idx_ff     <= idx_ff;
      cmp_slot_ok_ff <= slot_valid_ff[idx_ff];
      if (req_take) begin
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         if (cmp_vld_ff && cmp_slot_ok_ff && mem_rd_data_ff == val_ff) begin
            found_ff     <= 1'b1;
            found_idx_ff <= cmp_idx_ff;
         end
         if (state_ff == ST_SCAN && !slot_valid_ff[idx_ff] && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= idx_ff;
         end
      end
   end

   // random walk: one lfsr step and one remainder sample per occupied slot
   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= LFSR_INIT;
      end else if (csr_wr_en) begin
         lfsr_ff <= (csr_wr_data != '0) ? csr_wr_data : LFSR_INIT;
      end else if (walk_hit) begin
         lfsr_ff <= lfsr_next;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         k_ff <= '0;
      end else if (walk_hit) begin
         k_ff <= k_ff + 1'b1;
      end
   end

   assign mod_req.valid    = walk_hit;
   assign mod_req.dividend = lfsr_next;
   assign mod_req.divisor  = k_ff + 1'b1;
   assign mod_req.slot     = idx_ff;

   rset_mod_pipe u_mod_pipe (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   // latest slot whose sample divides evenly is the pick
   always_ff @(posedge clock) begin
      if (req_take) begin
         pick_found_ff <= 1'b0;
      end else if (mod_rsp.valid && mod_rsp.zero) begin
         pick_found_ff <= 1'b1;
         pick_idx_ff   <= mod_rsp.slot;
      end
   end

   // outcome of the operation
   always_comb begin
      fin_ok   = 1'b0;
      fin_full = 1'b0;
      fin_set  = 1'b0;
      fin_clr  = 1'b0;
      fin_pick = NO_PICK;
      unique case (op_ff)
         OP_INSERT: begin
            if (!found_ff) begin
               if (free_found_ff) begin
                  fin_ok  = 1'b1;
                  fin_set = 1'b1;
               end else begin
                  fin_full = 1'b1;
               end
            end
         end
         OP_REMOVE: begin
            if (found_ff) begin
               fin_ok  = 1'b1;
               fin_clr = 1'b1;
            end
         end
         OP_GET: begin
            fin_ok = (k_ff != '0);
            if (pick_found_ff) fin_pick = mem_rd_data_ff;
         end
         default: begin
            fin_ok = 1'b0;
         end
      endcase
   end

   assign mem_we = finish_go && fin_set;

   // set bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         count_ff      <= '0;
      end else if (finish_go) begin
         if (fin_set) begin
            slot_valid_ff[free_idx_ff] <= 1'b1;
            count_ff                   <= count_ff + 1'b1;
         end else if (fin_clr) begin
            slot_valid_ff[found_idx_ff] <= 1'b0;
            count_ff                    <= count_ff - 1'b1;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (finish_go) begin
         rsp_ok_ff   <= fin_ok;
         rsp_full_ff <= fin_full;
         rsp_pick_ff <= fin_pick;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.succeeded    = rsp_ok_ff;
   assign rsp_if.picked_value = rsp_pick_ff;
   assign rsp_if.table_full   = rsp_full_ff;

`ifndef SYNTH
   // the element count follows the valid bits
   assert property (@(posedge clock) disable iff (reset)
      $countones(slot_valid_ff) == count_ff)
      else $error("element count differs from occupied slots");

   // the walk never counts more slots than are occupied
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK || state_ff == ST_DRAIN) |-> (k_ff <= count_ff))
      else $error("walk count exceeds element count");

   // a nonempty walk always ends with a pick
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && op_ff == OP_GET && k_ff != '0) |-> pick_found_ff)
      else $error("nonempty get random without a pick");

   // an insert that stores a value targets a free slot
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !slot_valid_ff[free_idx_ff])
      else $error("insert overwrites an occupied slot");
`endif

endmodule

`default_nettype wire

### rtl/core/rset_mod_pipe.sv
// pipelined remainder unit: tells whether a random sample is a multiple of the running
// count; restoring remainder over MOD_STAGES stages; depends on rset_pkg
`default_nettype none

module rset_mod_pipe import rset_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mod_req_type mod_req,
   output mod_rsp_type mod_rsp
);

   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] dividend;
      logic [CNT_W-1:0]  divisor;
      logic [CNT_W-1:0]  rem;
      logic [IDX_W-1:0]  slot;
   } stage_type;

   stage_type stage_ff [MOD_STAGES];
   stage_type stage_in [MOD_STAGES];
   logic      busy;

   // shift MOD_STEPS dividend bits into the partial remainder, msb first
   function automatic logic [CNT_W-1:0] rem_steps(input logic [CNT_W-1:0] rem,
                                                  input logic [MOD_STEPS-1:0] bits,
                                                  input logic [CNT_W-1:0] divisor);
      logic [CNT_W:0]   part;
      logic [CNT_W-1:0] r;
      r = rem;
      for (int i = MOD_STEPS - 1; i >= 0; i--) begin
         part = {r, bits[i]};
         if (part >= {1'b0, divisor}) begin
            part = part - {1'b0, divisor};
         end
         r = part[CNT_W-1:0];
      end
      return r;
   endfunction

   // next value of every stage, valid bits forced low during reset
   always_comb begin
      stage_type src;
      for (int s = 0; s < MOD_STAGES; s++) begin
         if (s == 0) begin
            src.valid    = mod_req.valid;
            src.dividend = mod_req.dividend;
            src.divisor  = mod_req.divisor;
            src.rem      = '0;
            src.slot     = mod_req.slot;
         end else begin
            src = stage_ff[s-1];
         end
         stage_in[s]       = src;
         stage_in[s].valid = src.valid && !reset;
         stage_in[s].rem   = rem_steps(src.rem,
                                       src.dividend[DATA_W-1-s*MOD_STEPS -: MOD_STEPS],
                                       src.divisor);
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      for (int s = 0; s < MOD_STAGES; s++) begin
         stage_ff[s] <= stage_in[s];
      end
   end

   // occupancy
   always_comb begin
      busy = 1'b0;
      for (int s = 0; s < MOD_STAGES; s++) begin
         busy = busy | stage_ff[s].valid;
      end
   end

   assign mod_rsp.busy  = busy;
   assign mod_rsp.valid = stage_ff[MOD_STAGES-1].valid;
   assign mod_rsp.zero  = (stage_ff[MOD_STAGES-1].rem == '0);
   assign mod_rsp.slot  = stage_ff[MOD_STAGES-1].slot;

endmodule

`default_nettype wire
